// File: sv/accel_tilt_angle_defines.svh
// ----------------------------------------------------------------------------
// Accelerometer tilt angle assertion macros
// Shared property wrappers for the tilt angle pipeline.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_DEFINES_SVH

// same-cycle implication
`define ATA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ata_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle package
// Request and response types, pipeline cell types and fixed constants.
// ----------------------------------------------------------------------------
package ata_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_z;
  } ata_req_t;

  typedef struct packed {
    logic signed [15:0] tilt_angle;
    logic               range_error;
  } ata_rsp_t;

  typedef enum logic [1:0] {
    CFG_X_RAW_MIN,
    CFG_X_RAW_MAX,
    CFG_Z_RAW_MIN,
    CFG_Z_RAW_MAX
  } cfg_idx_e;

  localparam logic signed [15:0] X_RAW_MIN_RST = -16'sd15924;
  localparam logic signed [15:0] X_RAW_MAX_RST = 16'sd16629;
  localparam logic signed [15:0] Z_RAW_MIN_RST = -16'sd17454;
  localparam logic signed [15:0] Z_RAW_MAX_RST = 16'sd15750;

  localparam int DIV_STEPS    = 32;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 34;
  localparam int RND_STEPS    = 4;

  localparam int NRM_W = 41;
  localparam int CX_W  = 45;
  localparam int ANG_W = 36;
  localparam int NUM_W = 48;
  localparam int RN_W  = 49;

  // reciprocal estimate: quotient = ((x >> RND_PRE) * RND_RECIP) >> RND_SH
  localparam int RND_PRE = 21;
  localparam int RND_SH  = 31;
  localparam int PRD_W   = 45;

  localparam logic [32:0]        ANG_LIM    = 33'd6746518852;
  localparam logic [33:0]        PI_Q32     = 34'd13493037705;
  localparam logic [34:0]        RND_DIV    = 35'd26986075410;
  localparam logic [17:0]        RND_RECIP  = 18'd166886;
  localparam logic [14:0]        DEG_SCALE  = 15'd23040;
  localparam logic [13:0]        QUARTER    = 14'd11520;
  localparam logic signed [15:0] HALF_TURN  = 16'sd23040;
  localparam logic signed [33:0] SCALE_OFS  = 34'sd16384;

  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] nq;
    logic [15:0] den;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  cy;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic xneg;
    logic zneg;
  } flags_t;

  function automatic longint unsigned ata_udiv(input longint unsigned a,
                                               input longint unsigned b);
    longint unsigned rem;
    longint unsigned q;
    rem = 0;
    q   = 0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], a[k]};
      if (rem >= b) begin
        rem  = rem - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in radians, 32 fraction bits
  function automatic longint ata_atan_step(input int i);
    longint acc;
    longint term;
    bit     neg;
    acc = 0;
    neg = 1'b0;
    if (i == 0) return 64'sd3373259426;
    for (int n = 1; i * n <= 60; n += 2) begin
      term = longint'(ata_udiv(64'd1 << (60 - i * n), longint'(n)));
      acc  = neg ? acc - term : acc + term;
      neg  = !neg;
    end
    return (acc + (64'sd1 <<< 27)) >>> 28;
  endfunction

endpackage

// File: sv/ata_div_cell.sv
// ----------------------------------------------------------------------------
// Tilt angle divider cell
// One restoring quotient bit per cell of the rescale divider chain.
// ----------------------------------------------------------------------------
module ata_div_cell import ata_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  div_lane_t lane_i,
  output div_lane_t lane_o
);

  logic [16:0] trial;
  logic        fit;
  div_lane_t   lane_d;
  div_lane_t   lane_q;

  always_comb begin
    trial       = {lane_i.rem, lane_i.nq[31]};
    fit         = trial >= {1'b0, lane_i.den};
    lane_d      = lane_i;
    lane_d.rem  = fit ? 16'(trial - {1'b0, lane_i.den}) : trial[15:0];
    lane_d.nq   = {lane_i.nq[30:0], fit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

// File: sv/ata_cordic_cell.sv
// ----------------------------------------------------------------------------
// Tilt angle CORDIC cell
// One vectoring rotation with its fixed arctangent step.
// ----------------------------------------------------------------------------
module ata_cordic_cell import ata_pkg::*; #(
  parameter int Step = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t vec_i,
  output cordic_t vec_o
);

  localparam logic signed [ANG_W-1:0] AtanStep = ANG_W'(ata_atan_step(Step));

  logic signed [CX_W-1:0]  cx;
  logic signed [CX_W-1:0]  cy;
  logic signed [ANG_W-1:0] ang;
  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;
  cordic_t                 vec_d;
  cordic_t                 vec_q;

  always_comb begin
    cx  = vec_i.cx;
    cy  = vec_i.cy;
    ang = vec_i.ang;
    dx  = cy >>> Step;
    dy  = cx >>> Step;
    if (cy > 0) begin
      vec_d.cx  = cx + dx;
      vec_d.cy  = cy - dy;
      vec_d.ang = ang + AtanStep;
    end else begin
      vec_d.cx  = cx - dx;
      vec_d.cy  = cy + dy;
      vec_d.ang = ang - AtanStep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule

// File: sv/accel_tilt_angle.sv
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// The pipeline includes the 32-cell rescale divider, 6 normalize stages, 34 CORDIC
// cells and the 4-stage reciprocal rounding.
// Reset: clears all valid bits and loads the default calibration ranges.
// ----------------------------------------------------------------------------
// Accelerometer tilt angle
// Rescales an X/Z sample pair and resolves atan2 in degrees, 7 fraction bits.
// ----------------------------------------------------------------------------
`include "accel_tilt_angle_defines.svh"

module accel_tilt_angle import ata_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ata_req_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ata_rsp_t    out_rsp_o
);

  localparam int DEPTH = 2 + DIV_STEPS + NORM_STEPS + CORDIC_STEPS + 2 + RND_STEPS + 1;
  localparam int FL_N  = 1 + NORM_STEPS + CORDIC_STEPS + 2 + RND_STEPS;

  logic [15:0] x_min_q, x_max_q, z_min_q, z_max_q;
  logic [DEPTH-1:0] vld_q;
  logic en;

  div_lane_t dx_lane [DIV_STEPS+1];
  div_lane_t dz_lane [DIV_STEPS+1];
  div_lane_t x0_d, z0_d;
  logic      errc_q [DIV_STEPS+1];

  logic signed [33:0] sx, sz;
  logic [31:0]        ax, az;
  flags_t             fl_q [FL_N];
  flags_t             fl0_d;

  logic [NRM_W-1:0] na_q [NORM_STEPS+1];
  logic [NRM_W-1:0] nb_q [NORM_STEPS+1];

  cordic_t cvec [CORDIC_STEPS+1];

  logic signed [ANG_W-1:0] ang_raw;
  logic [32:0]             ang_c;
  logic [NUM_W-1:0]        num_q;
  logic [RN_W-1:0]         rnd_q;
  logic [PRD_W-1:0]        prod_q;
  logic [RN_W-1:0]         xa_q, xb_q;
  logic [13:0]             qe_q, qc_q;
  logic [RN_W-1:0]         rc_q;
  logic [13:0]             qt_q;

  logic [13:0]        res;
  logic signed [15:0] ang16;
  ata_rsp_t           rsp_d, rsp_q;

  function automatic div_lane_t lane_init(input logic [15:0] v, input logic [15:0] lo,
                                          input logic [15:0] hi);
    logic [16:0] diff;
    logic [16:0] den;
    logic [16:0] mag;
    logic [16:0] dmag;
    div_lane_t   l;
    diff   = {v[15], v} - {lo[15], lo};
    den    = {hi[15], hi} - {lo[15], lo};
    mag    = diff[16] ? 17'(-diff) : diff;
    dmag   = den[16] ? 17'(-den) : den;
    l.rem  = '0;
    l.nq   = {1'b0, mag[15:0], 15'b0};
    l.den  = dmag[15:0];
    l.neg  = diff[16] ^ den[16];
    return l;
  endfunction

  function automatic logic signed [33:0] scaled(input div_lane_t l);
    logic signed [33:0] q;
    q = $signed({2'b0, l.nq});
    return (l.neg ? -q : q) - SCALE_OFS;
  endfunction

  assign en         = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= X_RAW_MIN_RST;
      x_max_q <= X_RAW_MAX_RST;
      z_min_q <= Z_RAW_MIN_RST;
      z_max_q <= Z_RAW_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_RAW_MIN: x_min_q <= cfg_wdata_i;
        CFG_X_RAW_MAX: x_max_q <= cfg_wdata_i;
        CFG_Z_RAW_MIN: z_min_q <= cfg_wdata_i;
        CFG_Z_RAW_MAX: z_max_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // request capture
  assign x0_d = lane_init(in_req_i.accel_x, x_min_q, x_max_q);
  assign z0_d = lane_init(in_req_i.accel_z, z_min_q, z_max_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_lane[0] <= x0_d;
      dz_lane[0] <= z0_d;
      errc_q[0]  <= (x_max_q == x_min_q) || (z_max_q == z_min_q);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    ata_div_cell u_dx (.clk_i, .en_i(en), .lane_i(dx_lane[k]), .lane_o(dx_lane[k+1]));
    ata_div_cell u_dz (.clk_i, .en_i(en), .lane_i(dz_lane[k]), .lane_o(dz_lane[k+1]));
    always_ff @(posedge clk_i) begin
      if (en) errc_q[k+1] <= errc_q[k];
    end
  end

  // fold into first quadrant
  always_comb begin
    sx         = scaled(dx_lane[DIV_STEPS]);
    sz         = scaled(dz_lane[DIV_STEPS]);
    ax         = sx[33] ? 32'(-sx) : sx[31:0];
    az         = sz[33] ? 32'(-sz) : sz[31:0];
    fl0_d.err  = errc_q[DIV_STEPS];
    fl0_d.zero = (sx == '0) && (sz == '0);
    fl0_d.xneg = sx[33];
    fl0_d.zneg = sz[33];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_q[0] <= NRM_W'(ax);
      nb_q[0] <= NRM_W'(az);
      fl_q[0] <= fl0_d;
    end
  end

  for (genvar i = 1; i < FL_N; i++) begin : g_flags
    always_ff @(posedge clk_i) begin
      if (en) fl_q[i] <= fl_q[i-1];
    end
  end

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int Sh = 32 >> k;
    logic fits;
    assign fits = ((na_q[k] | nb_q[k]) >> (NRM_W - Sh)) == '0;
    always_ff @(posedge clk_i) begin
      if (en) begin
        na_q[k+1] <= fits ? na_q[k] << Sh : na_q[k];
        nb_q[k+1] <= fits ? nb_q[k] << Sh : nb_q[k];
      end
    end
  end

  assign cvec[0].cx  = $signed(CX_W'(nb_q[NORM_STEPS]));
  assign cvec[0].cy  = $signed(CX_W'(na_q[NORM_STEPS]));
  assign cvec[0].ang = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    ata_cordic_cell #(.Step(k)) u_cell (
      .clk_i,
      .en_i (en),
      .vec_i(cvec[k]),
      .vec_o(cvec[k+1])
    );
  end

  // clamp and scale to degrees
  always_comb begin
    ang_raw = cvec[CORDIC_STEPS].ang;
    if (ang_raw < 0) begin
      ang_c = '0;
    end else if (ang_raw > $signed({3'b0, ANG_LIM})) begin
      ang_c = ANG_LIM;
    end else begin
      ang_c = ang_raw[32:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= NUM_W'(ang_c) * NUM_W'(DEG_SCALE);
      rnd_q <= {num_q, 1'b0} + RN_W'(PI_Q32);
    end
  end

  // estimate the quotient from below, then correct by one
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PRD_W'(rnd_q[RN_W-1:RND_PRE]) * PRD_W'(RND_RECIP);
      xa_q   <= rnd_q;
      qe_q   <= prod_q[PRD_W-1:RND_SH];
      xb_q   <= xa_q;
      rc_q   <= xb_q - RN_W'(qe_q) * RN_W'(RND_DIV);
      qc_q   <= qe_q;
      qt_q   <= qc_q + 14'(rc_q >= RN_W'(RND_DIV));
    end
  end

  always_comb begin
    res   = (qt_q > QUARTER) ? QUARTER : qt_q;
    ang16 = $signed(16'(res));
    if (fl_q[FL_N-1].zneg) ang16 = HALF_TURN - ang16;
    if (fl_q[FL_N-1].xneg) ang16 = -ang16;
    if (fl_q[FL_N-1].zero || fl_q[FL_N-1].err) ang16 = '0;
    rsp_d.tilt_angle  = ang16;
    rsp_d.range_error = fl_q[FL_N-1].err;
  end

  always_ff @(posedge clk_i) begin
    if (en) rsp_q <= rsp_d;
  end

  assign out_valid_o = vld_q[DEPTH-1];
  assign out_rsp_o   = rsp_q;

  `ATA_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && out_rsp_o.range_error, out_rsp_o.tilt_angle == '0, "range error with nonzero angle")
  `ATA_ASSERT_IMPL(a_angle_range, clk_i, rst_ni, out_valid_o, (out_rsp_o.tilt_angle <= HALF_TURN) && (out_rsp_o.tilt_angle >= -HALF_TURN), "angle beyond half turn")
  `ATA_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !en, $stable(vld_q), "pipeline moved during stall")

endmodule
